@@ hw/rtl/qsed_pkg.sv @@
// Types, constants and helper functions shared by the quoted-string escape decoder.
package qsed_pkg;

    localparam int CpWidth = 21;
    localparam int AccWidth = 32;
    localparam int MaxResults = 5;
    localparam int CntWidth = 3;

    localparam logic [CpWidth-1:0] QuoteReset = 21'h000022;
    localparam logic [CpWidth-1:0] CP_BACKSLASH = 21'h00005C;
    localparam logic [CpWidth-1:0] CP_LOWER_N = 21'h00006E;
    localparam logic [CpWidth-1:0] CP_LOWER_T = 21'h000074;
    localparam logic [CpWidth-1:0] CP_LOWER_R = 21'h000072;
    localparam logic [CpWidth-1:0] CP_ZERO = 21'h000030;
    localparam logic [CpWidth-1:0] CP_SQUOTE = 21'h000027;
    localparam logic [CpWidth-1:0] CP_DQUOTE = 21'h000022;
    localparam logic [CpWidth-1:0] CP_LOWER_X = 21'h000078;
    localparam logic [CpWidth-1:0] CP_LOWER_U = 21'h000075;
    localparam logic [CpWidth-1:0] CP_UPPER_U = 21'h000055;
    localparam logic [AccWidth-1:0] MaxCodepoint = 32'h0010FFFF;

    localparam logic [3:0] DigitsX = 4'd2;
    localparam logic [3:0] DigitsSmallU = 4'd4;
    localparam logic [3:0] DigitsBigU = 4'd8;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_BODY   = 2'd1,
        PH_ESCAPE = 2'd2,
        PH_HEX    = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        KIND_DATA   = 2'd0,
        KIND_DONE   = 2'd1,
        KIND_NOOPEN = 2'd2,
        KIND_BAD    = 2'd3
    } t_kind;

    typedef struct packed {
        logic [CpWidth-1:0] codepoint;
        logic               at_end;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        t_kind      kind;
        logic       last;
    } t_out_item;

    typedef struct packed {
        t_phase              phase;
        logic [AccWidth-1:0] hex_accumulator;
        logic [3:0]          digits_left;
        logic                hex_gives_raw_byte;
    } t_state;

    // Results of one item; byte 0 sits in the low bits. A count of zero means no result.
    typedef struct packed {
        logic [8*MaxResults-1:0] bytes;
        logic [CntWidth-1:0]     count;
        t_kind                   kind;
    } t_bundle;

    typedef struct packed {
        logic [31:0] bytes;
        logic [2:0]  count;
    } t_utf8;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } t_hex;

    function automatic t_utf8 utf8_encode(input logic [CpWidth-1:0] v);
        t_utf8 r;
        r = '0;
        if (v < 21'h80) begin
            r.bytes = {24'h0, v[7:0]};
            r.count = 3'd1;
        end else if (v < 21'h800) begin
            r.bytes = {16'h0, 2'b10, v[5:0], 3'b110, v[10:6]};
            r.count = 3'd2;
        end else if (v < 21'h10000) begin
            r.bytes = {8'h0, 2'b10, v[5:0], 2'b10, v[11:6], 4'b1110, v[15:12]};
            r.count = 3'd3;
        end else begin
            r.bytes = {2'b10, v[5:0], 2'b10, v[11:6], 2'b10, v[17:12], 5'b11110, v[20:18]};
            r.count = 3'd4;
        end
        return r;
    endfunction

    function automatic t_hex hex_digit(input logic [CpWidth-1:0] c);
        t_hex r;
        r = '0;
        if (c inside {[21'h30:21'h39]}) begin
            r.valid = 1'b1;
            r.value = c[3:0];
        end else if (c inside {[21'h61:21'h66], [21'h41:21'h46]}) begin
            r.valid = 1'b1;
            r.value = 4'(c[3:0] + 4'd9);
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/quoted_string_escape_decoder.sv @@
// Top level of the quoted-string escape decoder: state, result register and handshakes.
//
// The decoder takes one codepoint item per clock and turns a quoted string into a stream of
// UTF-8 byte items followed by a status item. Each accepted item is decoded in the cycle it is
// accepted, and all of its results (up to five: a backslash plus a four-byte sequence) land in
// one result register that is drained one result item per cycle. An item that gives zero or one
// result does not hold the input, so plain ASCII text and quotes run at one item per clock.
// An item that gives more results holds the input side until its last result leaves,
// because the result register hands out one item per cycle; the next item is taken in the same
// cycle as the final result of the previous one leaves. An output stall stalls the input while
// the result register holds results, since it keeps the results of only one item at a time.
// The quote character is written through the configuration channel, which is always ready; it
// must only be changed while the decoder has no results pending.
module quoted_string_escape_decoder
    import qsed_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_in_item           i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out_item          o_out_item,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [CpWidth-1:0] i_cfg_quote_char
);

    t_state                  r_state;
    t_state                  n_state;
    logic [CpWidth-1:0]      r_quote;
    logic [8*MaxResults-1:0] r_bytes;
    logic [CntWidth-1:0]     r_left;
    t_kind                   r_kind;
    t_bundle                 step_bundle;
    logic                    pop;
    logic                    accept;

    // The decode itself is pure logic from the accepted item and the current state.
    qsed_step u_step (
        .i_state      (r_state),
        .i_quote_char (r_quote),
        .i_item       (i_in_item),
        .o_state      (n_state),
        .o_bundle     (step_bundle)
    );

    // The result register shows its lowest byte; popping shifts the next byte down.
    assign o_out_valid = (r_left != '0);
    assign pop = o_out_valid && i_out_ready;
    assign o_out_item.out_byte = r_bytes[7:0];
    assign o_out_item.kind = r_kind;
    assign o_out_item.last = (r_left == CntWidth'(1));

    // A new item is taken when the result register is empty or its final result leaves now.
    assign o_in_ready = (r_left == '0) || (pop && r_left == CntWidth'(1));
    assign accept = i_in_valid && o_in_ready;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quote <= QuoteReset;
        end else if (i_cfg_valid) begin
            r_quote <= i_cfg_quote_char;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{PH_IDLE, '0, '0, 1'b0};
        end else if (accept) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (accept && step_bundle.count != '0) begin
            r_left <= step_bundle.count;
        end else if (pop) begin
            r_left <= CntWidth'(r_left - CntWidth'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && step_bundle.count != '0) begin
            r_bytes <= step_bundle.bytes;
            r_kind <= step_bundle.kind;
        end else if (pop) begin
            r_bytes <= {8'h00, r_bytes[8*MaxResults-1:8]};
        end
    end

    // A hex escape always has digits still to come.
    a_hex_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.phase == PH_HEX |-> r_state.digits_left != 4'd0)
        else $error("hex phase with no digits left");

    // Outside a hex escape the accumulator and its flags are cleared.
    a_hex_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.phase != PH_HEX |->
            r_state.hex_accumulator == '0 && r_state.digits_left == 4'd0
            && !r_state.hex_gives_raw_byte)
        else $error("hex state left over outside a hex escape");

    // A status item is alone for its input item and carries a zero byte.
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.kind != KIND_DATA |->
            o_out_item.last && o_out_item.out_byte == 8'h00)
        else $error("status item not final or byte not zero");

    // While results are on show, the input only opens on the final result of the previous item.
    a_ready_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready && o_out_valid |-> o_out_item.last)
        else $error("input taken before previous results were drained");

    // A popped non-final result is followed by another result of the same item.
    a_burst_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop && !o_out_item.last |=> o_out_valid && $stable(r_kind))
        else $error("result burst broken");

endmodule

@@ hw/rtl/qsed_step.sv @@
// Next-state and result logic for one accepted item of the escape decoder.
module qsed_step
    import qsed_pkg::*;
(
    input  t_state                   i_state,
    input  logic [CpWidth-1:0]       i_quote_char,
    input  t_in_item                 i_item,
    output t_state                   o_state,
    output t_bundle                  o_bundle
);

    logic [CpWidth-1:0]  cp;
    logic                at_end;
    t_utf8               enc_cp;
    t_utf8               enc_hex;
    t_hex                hv;
    logic [AccWidth-1:0] acc_new;
    logic [3:0]          digits_new;

    assign cp = i_item.codepoint;
    assign at_end = i_item.at_end;
    assign enc_cp = utf8_encode(cp);
    assign hv = hex_digit(cp);
    assign acc_new = {i_state.hex_accumulator[AccWidth-5:0], hv.value};
    assign digits_new = (i_state.digits_left != 4'd0) ? 4'(i_state.digits_left - 4'd1) : 4'd0;
    assign enc_hex = utf8_encode(acc_new[CpWidth-1:0]);

    always_comb begin
        t_bundle fin;
        fin = '{bytes: '0, count: 3'd1, kind: KIND_BAD};
        o_state = i_state;
        o_bundle = '{bytes: '0, count: '0, kind: KIND_DATA};

        case (i_state.phase)
            PH_IDLE: begin
                if (!at_end && cp == i_quote_char) begin
                    o_state.phase = PH_BODY;
                end else begin
                    o_state = '{PH_IDLE, '0, '0, 1'b0};
                    o_bundle = fin;
                    o_bundle.kind = KIND_NOOPEN;
                end
            end
            PH_BODY: begin
                if (at_end) begin
                    o_state = '{PH_IDLE, '0, '0, 1'b0};
                    o_bundle = fin;
                end else if (cp == i_quote_char) begin
                    o_state = '{PH_IDLE, '0, '0, 1'b0};
                    o_bundle = fin;
                    o_bundle.kind = KIND_DONE;
                end else if (cp == CP_BACKSLASH) begin
                    o_state.phase = PH_ESCAPE;
                end else begin
                    o_bundle.bytes = {8'h00, enc_cp.bytes};
                    o_bundle.count = enc_cp.count;
                end
            end
            PH_ESCAPE: begin
                if (at_end) begin
                    o_state = '{PH_IDLE, '0, '0, 1'b0};
                    o_bundle = fin;
                end else begin
                    o_state.phase = PH_BODY;
                    o_bundle.count = 3'd1;
                    case (cp)
                        CP_BACKSLASH: o_bundle.bytes = 40'h5C;
                        CP_LOWER_N:   o_bundle.bytes = 40'h0A;
                        CP_LOWER_T:   o_bundle.bytes = 40'h09;
                        CP_LOWER_R:   o_bundle.bytes = 40'h0D;
                        CP_ZERO:      o_bundle.bytes = 40'h00;
                        CP_SQUOTE:    o_bundle.bytes = 40'h27;
                        CP_DQUOTE:    o_bundle.bytes = 40'h22;
                        CP_LOWER_X: begin
                            o_state = '{PH_HEX, '0, DigitsX, 1'b1};
                            o_bundle.count = '0;
                        end
                        CP_LOWER_U: begin
                            o_state = '{PH_HEX, '0, DigitsSmallU, 1'b0};
                            o_bundle.count = '0;
                        end
                        CP_UPPER_U: begin
                            o_state = '{PH_HEX, '0, DigitsBigU, 1'b0};
                            o_bundle.count = '0;
                        end
                        default: begin
                            // Unknown escape keeps its backslash in front.
                            o_bundle.bytes = {enc_cp.bytes, 8'h5C};
                            o_bundle.count = 3'(enc_cp.count + 3'd1);
                        end
                    endcase
                end
            end
            PH_HEX: begin
                if (at_end || !hv.valid) begin
                    o_state = '{PH_IDLE, '0, '0, 1'b0};
                    o_bundle = fin;
                end else if (digits_new != 4'd0) begin
                    o_state.hex_accumulator = acc_new;
                    o_state.digits_left = digits_new;
                end else if (i_state.hex_gives_raw_byte) begin
                    o_state = '{PH_BODY, '0, '0, 1'b0};
                    o_bundle.bytes = {32'h0, acc_new[7:0]};
                    o_bundle.count = 3'd1;
                end else if (acc_new > MaxCodepoint) begin
                    o_state = '{PH_IDLE, '0, '0, 1'b0};
                    o_bundle = fin;
                end else begin
                    o_state = '{PH_BODY, '0, '0, 1'b0};
                    o_bundle.bytes = {8'h00, enc_hex.bytes};
                    o_bundle.count = enc_hex.count;
                end
            end
            default: begin
                o_state = '{PH_IDLE, '0, '0, 1'b0};
            end
        endcase
    end

endmodule

@@ tb/tb_quoted_string_escape_decoder.sv @@
// Self-checking testbench for the quoted-string escape decoder, with a UTF-8 predictor.
module tb_quoted_string_escape_decoder;
    import qsed_pkg::*;

    localparam int SettleCycles  = 8;
    localparam int ItemsPerPhase = 35;
    localparam int NumPhases     = 7;
    localparam int HoldOffCycles = 80;
    localparam int CycleLimit    = 200000;

    // Predicts the items that the decoder produces and checks each one as it leaves.
    // It keeps its own copy of the quote character and of the decoder state.
    class utf8_string_scoreboard;
        logic [CpWidth-1:0]  open_quote;
        t_phase              ph;
        logic [AccWidth-1:0] hex_acc;
        logic [3:0]          hex_left;
        logic                hex_raw;
        logic [7:0]          byte_buf[$];
        t_out_item           pending_decoded[$];
        int                  mismatches;
        int                  results_seen;
        int                  kind_seen[4];

        function new();
            open_quote = QuoteReset;
            ph = PH_IDLE;
            hex_acc = '0;
            hex_left = '0;
            hex_raw = 1'b0;
            mismatches = 0;
            results_seen = 0;
            foreach (kind_seen[k]) kind_seen[k] = 0;
        endfunction

        function void set_quote(logic [CpWidth-1:0] q);
            open_quote = q;
        endfunction

        function int hex_nibble(logic [CpWidth-1:0] c);
            if (c >= CP_ZERO && c <= 21'h39) return int'(c - CP_ZERO);
            if (c >= 21'h61 && c <= 21'h66) return int'(c - 21'h61) + 10;
            if (c >= 21'h41 && c <= 21'h46) return int'(c - 21'h41) + 10;
            return -1;
        endfunction

        // Appends the UTF-8 form of a 21-bit value to the byte buffer.
        function void add_utf8(logic [CpWidth-1:0] v);
            if (v < 21'h80) begin
                byte_buf.push_back(v[7:0]);
            end else if (v < 21'h800) begin
                byte_buf.push_back({3'b110, v[10:6]});
                byte_buf.push_back({2'b10, v[5:0]});
            end else if (v < 21'h10000) begin
                byte_buf.push_back({4'b1110, v[15:12]});
                byte_buf.push_back({2'b10, v[11:6]});
                byte_buf.push_back({2'b10, v[5:0]});
            end else begin
                byte_buf.push_back({5'b11110, v[20:18]});
                byte_buf.push_back({2'b10, v[17:12]});
                byte_buf.push_back({2'b10, v[11:6]});
                byte_buf.push_back({2'b10, v[5:0]});
            end
        endfunction

        // Moves the buffered bytes to the expectations, flagging the final one.
        function void flush_bytes();
            t_out_item r;
            foreach (byte_buf[k]) begin
                r.out_byte = byte_buf[k];
                r.kind = KIND_DATA;
                r.last = (k == byte_buf.size() - 1);
                pending_decoded.push_back(r);
            end
            byte_buf.delete();
        endfunction

        function void finish_string(t_kind k);
            t_out_item r;
            r.out_byte = 8'h00;
            r.kind = k;
            r.last = 1'b1;
            pending_decoded.push_back(r);
            ph = PH_IDLE;
            hex_acc = '0;
            hex_left = '0;
            hex_raw = 1'b0;
        endfunction

        function void arm_hex(logic [3:0] ndigits, logic raw);
            ph = PH_HEX;
            hex_acc = '0;
            hex_left = ndigits;
            hex_raw = raw;
        endfunction

        // Called once for every accepted input item.
        function void take_codepoint(t_in_item it);
            logic [CpWidth-1:0] cp;
            int hv;
            cp = it.codepoint;
            case (ph)
                PH_IDLE: begin
                    if (!it.at_end && cp == open_quote) ph = PH_BODY;
                    else finish_string(KIND_NOOPEN);
                end
                PH_BODY: begin
                    // The closing quote wins even over a backslash.
                    if (it.at_end) finish_string(KIND_BAD);
                    else if (cp == open_quote) finish_string(KIND_DONE);
                    else if (cp == CP_BACKSLASH) ph = PH_ESCAPE;
                    else begin
                        add_utf8(cp);
                        flush_bytes();
                    end
                end
                PH_ESCAPE: begin
                    if (it.at_end) begin
                        finish_string(KIND_BAD);
                    end else begin
                        ph = PH_BODY;
                        case (cp)
                            CP_BACKSLASH: byte_buf.push_back(8'h5C);
                            CP_LOWER_N:   byte_buf.push_back(8'h0A);
                            CP_LOWER_T:   byte_buf.push_back(8'h09);
                            CP_LOWER_R:   byte_buf.push_back(8'h0D);
                            CP_ZERO:      byte_buf.push_back(8'h00);
                            CP_SQUOTE:    byte_buf.push_back(8'h27);
                            CP_DQUOTE:    byte_buf.push_back(8'h22);
                            CP_LOWER_X:   arm_hex(DigitsX, 1'b1);
                            CP_LOWER_U:   arm_hex(DigitsSmallU, 1'b0);
                            CP_UPPER_U:   arm_hex(DigitsBigU, 1'b0);
                            default: begin
                                // Unknown escapes keep their backslash.
                                byte_buf.push_back(8'h5C);
                                add_utf8(cp);
                            end
                        endcase
                        flush_bytes();
                    end
                end
                default: begin
                    hv = hex_nibble(cp);
                    if (it.at_end || hv < 0) begin
                        finish_string(KIND_BAD);
                    end else begin
                        hex_acc = {hex_acc[AccWidth-5:0], 4'(hv)};
                        if (hex_left != 0) hex_left = hex_left - 4'd1;
                        if (hex_left == 0) begin
                            ph = PH_BODY;
                            if (!hex_raw && hex_acc > MaxCodepoint) begin
                                finish_string(KIND_BAD);
                            end else begin
                                if (hex_raw) byte_buf.push_back(hex_acc[7:0]);
                                else add_utf8(hex_acc[CpWidth-1:0]);
                                hex_acc = '0;
                                hex_raw = 1'b0;
                                flush_bytes();
                            end
                        end
                    end
                end
            endcase
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            results_seen++;
            if (pending_decoded.size() == 0) begin
                $display("%0t: result with nothing expected: byte=%h kind=%0d last=%b",
                         $time, got.out_byte, got.kind, got.last);
                mismatches++;
            end else begin
                want = pending_decoded.pop_front();
                kind_seen[want.kind]++;
                if (got.out_byte !== want.out_byte) begin
                    $display("%0t: out_byte expected %h, got %h",
                             $time, want.out_byte, got.out_byte);
                    mismatches++;
                end
                if (got.kind !== want.kind) begin
                    $display("%0t: kind expected %0d, got %0d", $time, want.kind, got.kind);
                    mismatches++;
                end
                if (got.last !== want.last) begin
                    $display("%0t: last expected %b, got %b", $time, want.last, got.last);
                    mismatches++;
                end
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    t_in_item           in_item = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    t_out_item          out_item;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [CpWidth-1:0] cfg_quote = QuoteReset;

    utf8_string_scoreboard sb;
    logic [CpWidth-1:0]    cur_quote = QuoteReset;
    bit                    in_idle_en = 1'b1;
    bit                    out_idle_en = 1'b1;
    int                    out_hold_req = 0;
    int                    items_sent = 0;
    int                    quote_writes = 0;
    int                    cycle_count = 0;

    quoted_string_escape_decoder u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_in_item       (in_item),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_out_item      (out_item),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_quote_char(cfg_quote)
    );

    initial forever #5 clk = ~clk;

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("[quoted_string_escape_decoder] ERROR");
            $finish;
        end
    end

    // All handshakes are observed here, on values from before the edge. Inputs are noted
    // before results are checked, although a result never leaves in its input's own cycle.
    always @(posedge clk) begin
        if (rst_n) begin
            if (cfg_valid && cfg_ready) sb.set_quote(cfg_quote);
            if (in_valid && in_ready) sb.take_codepoint(in_item);
            if (out_valid && out_ready) sb.check_result(out_item);
        end
    end

    // Result side. A hold-off request stalls it for a counted stretch; otherwise it either
    // takes every item or drops ready at random.
    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge clk);
            if (out_hold_req != 0) begin
                stall_left = out_hold_req;
                out_hold_req = 0;
            end
            if (stall_left > 0) begin
                out_ready <= 1'b0;
                stall_left--;
            end else begin
                out_ready <= !(out_idle_en && $urandom_range(0, 99) < 36);
            end
        end
    end

    // Offers one item after an optional random gap, then holds it until it is taken.
    // Valid is only lowered inside the gap, so back-to-back items keep it high.
    task automatic send_item(input logic [CpWidth-1:0] cp, input logic fin);
        t_in_item it;
        it.codepoint = cp;
        it.at_end = fin;
        while (in_idle_en && $urandom_range(0, 99) < 36) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        do @(posedge clk); while (!in_ready);
        items_sent++;
    endtask

    task automatic send_cp(input logic [CpWidth-1:0] cp);
        send_item(cp, 1'b0);
    endtask

    // The codepoint that rides along with an end mark is ignored, so it is random.
    task automatic send_end();
        send_item(CpWidth'($urandom_range(0, 21'h1FFFFF)), 1'b1);
    endtask

    // The register is only written with the decoder idle and nothing pending.
    task automatic write_quote(input logic [CpWidth-1:0] q);
        cfg_valid <= 1'b1;
        cfg_quote <= q;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_quote = q;
        quote_writes++;
    endtask

    // The first edge lets the monitor note the item that was just accepted.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_decoded.size() != 0) @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
    endtask

    function automatic logic [CpWidth-1:0] hex_char(input logic [3:0] v);
        if (v < 4'd10) return CP_ZERO + CpWidth'(v);
        return (($urandom_range(0, 1) != 0) ? 21'h41 : 21'h61) + CpWidth'(v) - 21'd10;
    endfunction

    task automatic send_hex(input logic [31:0] v, input int ndigits);
        for (int i = ndigits - 1; i >= 0; i--) send_cp(hex_char(v[i*4 +: 4]));
    endtask

    // Any codepoint except the current quote and the backslash, across all UTF-8 lengths
    // and up to the full 21 bits.
    function automatic logic [CpWidth-1:0] pick_plain();
        logic [CpWidth-1:0] c;
        do begin
            case ($urandom_range(0, 5))
                0, 1:    c = CpWidth'($urandom_range(32, 126));
                2:       c = CpWidth'($urandom_range(0, 127));
                3:       c = CpWidth'($urandom_range(21'h80, 21'h7FF));
                4:       c = CpWidth'($urandom_range(21'h800, 21'hFFFF));
                default: c = CpWidth'($urandom_range(21'h10000, 21'h1FFFFF));
            endcase
        end while (c == cur_quote || c == CP_BACKSLASH);
        return c;
    endfunction

    // Mostly codepoints that sit just outside the hex digit ranges.
    function automatic logic [CpWidth-1:0] pick_non_hex();
        logic [CpWidth-1:0] c;
        case ($urandom_range(0, 7))
            0:       c = 21'h2F;
            1:       c = 21'h3A;
            2:       c = 21'h40;
            3:       c = 21'h47;
            4:       c = 21'h60;
            5:       c = 21'h67;
            default: c = CpWidth'($urandom_range(0, 21'h1FFFFF));
        endcase
        while (sb.hex_nibble(c) >= 0) c = CpWidth'($urandom_range(0, 21'h1FFFFF));
        return c;
    endfunction

    function automatic logic [CpWidth-1:0] simple_escape(input int k);
        case (k)
            0:       return CP_BACKSLASH;
            1:       return CP_LOWER_N;
            2:       return CP_LOWER_T;
            3:       return CP_LOWER_R;
            4:       return CP_ZERO;
            5:       return CP_SQUOTE;
            default: return CP_DQUOTE;
        endcase
    endfunction

    function automatic bit is_escape_letter(input logic [CpWidth-1:0] c);
        for (int k = 0; k < 7; k++) if (c == simple_escape(k)) return 1'b1;
        return c == CP_LOWER_X || c == CP_LOWER_U || c == CP_UPPER_U;
    endfunction

    // One well-formed piece of string body: a plain codepoint or one kind of escape.
    task automatic send_token();
        logic [CpWidth-1:0] c;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: send_cp(pick_plain());
            4: begin
                send_cp(CP_BACKSLASH);
                send_cp(simple_escape($urandom_range(0, 6)));
            end
            5: begin
                send_cp(CP_BACKSLASH);
                send_cp(CP_LOWER_X);
                send_hex($urandom_range(0, 255), 2);
            end
            6: begin
                // A quarter of the short escapes land on surrogates.
                send_cp(CP_BACKSLASH);
                send_cp(CP_LOWER_U);
                send_hex(($urandom_range(0, 3) == 0) ? $urandom_range(32'hD800, 32'hDFFF)
                                                     : $urandom_range(0, 32'hFFFF), 4);
            end
            7: begin
                send_cp(CP_BACKSLASH);
                send_cp(CP_UPPER_U);
                send_hex(($urandom_range(0, 3) == 0) ? MaxCodepoint
                                                     : $urandom_range(0, MaxCodepoint), 8);
            end
            default: begin
                do c = pick_plain(); while (is_escape_letter(c));
                send_cp(CP_BACKSLASH);
                send_cp(c);
            end
        endcase
    endtask

    task automatic send_good_string();
        send_cp(cur_quote);
        repeat ($urandom_range(0, 6)) send_token();
        send_cp(cur_quote);
    endtask

    // A string that goes wrong: text ending in the body, after a backslash or among hex
    // digits, a bad hex digit, or an oversized long escape.
    task automatic send_broken_string();
        int sel;
        int ndigits;
        send_cp(cur_quote);
        repeat ($urandom_range(0, 3)) send_token();
        case ($urandom_range(0, 4))
            0: send_end();
            1: begin
                send_cp(CP_BACKSLASH);
                send_end();
            end
            2, 3: begin
                sel = $urandom_range(0, 2);
                ndigits = (sel == 0) ? 2 : (sel == 1) ? 4 : 8;
                send_cp(CP_BACKSLASH);
                send_cp((sel == 0) ? CP_LOWER_X : (sel == 1) ? CP_LOWER_U : CP_UPPER_U);
                send_hex($urandom, $urandom_range(0, ndigits - 1));
                if ($urandom_range(0, 1) != 0) send_end();
                else send_cp(pick_non_hex());
            end
            default: begin
                send_cp(CP_BACKSLASH);
                send_cp(CP_UPPER_U);
                send_hex($urandom_range(MaxCodepoint + 1, 32'hFFFF_FFFF), 8);
            end
        endcase
    endtask

    function automatic logic [CpWidth-1:0] quote_for_phase(input int p);
        case (p)
            1:       return CP_SQUOTE;
            2:       return CP_BACKSLASH;
            3:       return '0;
            4:       return 21'h10FFFF;
            5:       return CpWidth'($urandom_range(0, 21'h10FFFF));
            default: return CP_DQUOTE;
        endcase
    endfunction

    initial begin : stimulus
        int goal;
        int pick;
        sb = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed items with the reset quote. Text outside a string, both as a stray
        // codepoint and as an end mark, has no opening quote.
        send_cp(21'h41);
        send_end();
        // The widest out-of-range codepoint, a lower surrogate spelled in mixed case, then
        // a bad digit in a byte escape.
        send_cp(cur_quote);
        send_cp(21'h1FFFFF);
        send_cp(CP_BACKSLASH);
        send_cp(CP_LOWER_U);
        send_cp(21'h64);
        send_cp(21'h46);
        send_cp(CP_ZERO);
        send_cp(CP_ZERO);
        send_cp(CP_BACKSLASH);
        send_cp(CP_LOWER_X);
        send_cp(21'h67);
        // A long escape just past the last codepoint.
        send_cp(cur_quote);
        send_cp(CP_BACKSLASH);
        send_cp(CP_UPPER_U);
        send_hex(MaxCodepoint + 1, 8);
        // Text that ends right after a backslash.
        send_cp(cur_quote);
        send_cp(CP_BACKSLASH);
        send_end();
        wait_drained();

        // Random phases; each after the first writes a quote character. The first keeps the reset
        // quote and starts with a long result stall while items keep coming, so the
        // decoder backs up into its input. The second runs with no idling on either side.
        for (int p = 0; p < NumPhases; p++) begin
            if (p > 0) write_quote(quote_for_phase(p));
            in_idle_en = (p >= 2);
            out_idle_en = (p != 1);
            if (p == 0) out_hold_req = HoldOffCycles;
            goal = items_sent + ItemsPerPhase;
            while (items_sent < goal) begin
                pick = $urandom_range(0, 99);
                if (pick < 75) send_good_string();
                else if (pick < 92) send_broken_string();
                else send_item(CpWidth'($urandom_range(0, 21'h1FFFFF)), $urandom_range(0, 3) == 0);
            end
            // An end mark leaves the decoder idle whatever state the phase ended in.
            send_end();
            wait_drained();
        end

        $display("Sent %0d codepoint items under %0d quote settings, checked %0d results:",
                 items_sent, quote_writes + 1, sb.results_seen);
        $display("%0d data bytes, %0d closed strings, %0d missing openings, %0d malformed.",
                 sb.kind_seen[KIND_DATA], sb.kind_seen[KIND_DONE],
                 sb.kind_seen[KIND_NOOPEN], sb.kind_seen[KIND_BAD]);
        if (sb.mismatches == 0 && sb.pending_decoded.size() == 0) begin
            $display("[quoted_string_escape_decoder] OK");
        end else begin
            $display("[quoted_string_escape_decoder] ERROR");
        end
        $finish;
    end

endmodule
